FILE: hw/rtl/sgwa_pkg.sv
package sgwa_pkg;

   // field widths
   localparam int TEMP_W = 16;
   localparam int TIME_W = 48;

   // history ring
   localparam int HISTORY_DEPTH_DEF = 15;
   localparam int CNT_W_DEF = $clog2(HISTORY_DEPTH_DEF + 1);
   localparam int SUM_W_DEF = TEMP_W + CNT_W_DEF;

   // register port
   localparam int PADDR_W = 5;
   localparam int PDATA_W = 64;
   localparam int REG_IDX_W = 2;

   localparam logic [REG_IDX_W-1:0] REG_MIN_TEMP    = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_MAX_TEMP    = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_LIFETIME_US = 2'd2;

   // register reset values
   localparam logic signed [TEMP_W-1:0] MIN_TEMP_RST    = 16'sd512;
   localparam logic signed [TEMP_W-1:0] MAX_TEMP_RST    = 16'sd10240;
   localparam logic [TIME_W-1:0]        LIFETIME_US_RST = 48'd900000000;

   // item kinds
   localparam logic ACTION_SAMPLE = 1'b0;
   localparam logic ACTION_QUERY  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] min_temp;
      logic signed [TEMP_W-1:0] max_temp;
      logic [TIME_W-1:0]        lifetime_us;
   } cfg_type;

   typedef struct packed {
      logic                     done;
      logic signed [TEMP_W-1:0] quotient;
   } div_rsp_type;

endpackage

FILE: hw/rtl/sgwa_ram.sv
module sgwa_ram
   import sgwa_pkg::*;
#(
   parameter int WIDTH = TEMP_W,
   parameter int DEPTH = HISTORY_DEPTH_DEF
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/sgwa_div.sv
module sgwa_div
   import sgwa_pkg::*;
#(
   parameter int SUM_W = SUM_W_DEF,
   parameter int CNT_W = CNT_W_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [SUM_W-1:0] dividend,
   input  logic [CNT_W-1:0]        divisor,
   output div_rsp_type             rsp
);

   localparam int STEP_W = $clog2(SUM_W);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] step_ff;
   logic              neg_ff;
   logic [SUM_W-1:0]  quo_ff;
   logic [CNT_W:0]    rem_ff;
   logic [CNT_W-1:0]  den_ff;

   logic [SUM_W-1:0]  mag;
   logic [CNT_W:0]    rem_shift;
   logic              fits;
   logic [CNT_W:0]    rem_next;
   logic [SUM_W-1:0]  quo_signed;

   // magnitude of the dividend, one restoring step per cycle
   always_comb begin
      mag = dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
      rem_shift = {rem_ff[CNT_W-1:0], quo_ff[SUM_W-1]};
      fits = (rem_shift >= {1'b0, den_ff});
      rem_next = fits ? (rem_shift - {1'b0, den_ff}) : rem_shift;
      quo_signed = neg_ff ? (~quo_ff + SUM_W'(1)) : quo_ff;
   end

   // step control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (step_ff == '0);
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (step_ff == '0)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // quotient and remainder
   always_ff @(posedge clock) begin
      if (start) begin
         step_ff <= STEP_W'(SUM_W - 1);
         neg_ff  <= dividend[SUM_W-1];
         quo_ff  <= mag;
         rem_ff  <= '0;
         den_ff  <= divisor;
      end else if (busy_ff) begin
         step_ff <= step_ff - STEP_W'(1);
         quo_ff  <= {quo_ff[SUM_W-2:0], fits};
         rem_ff  <= rem_next;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_signed[TEMP_W-1:0];

endmodule

FILE: hw/rtl/sgwa_csr.sv
module sgwa_csr
   import sgwa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready,
   output cfg_type            cfg
);

   cfg_type              cfg_ff;
   logic                 wr_en;
   logic [REG_IDX_W-1:0] reg_idx;

   // registers sit on 8 byte steps
   assign reg_idx = paddr[PADDR_W-1:3];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_temp    <= MIN_TEMP_RST;
         cfg_ff.max_temp    <= MAX_TEMP_RST;
         cfg_ff.lifetime_us <= LIFETIME_US_RST;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_MIN_TEMP:    cfg_ff.min_temp    <= pwdata[TEMP_W-1:0];
            REG_MAX_TEMP:    cfg_ff.max_temp    <= pwdata[TEMP_W-1:0];
            REG_LIFETIME_US: cfg_ff.lifetime_us <= pwdata[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      unique case (reg_idx)
         REG_MIN_TEMP:    prdata = PDATA_W'(cfg_ff.min_temp);
         REG_MAX_TEMP:    prdata = PDATA_W'(cfg_ff.max_temp);
         REG_LIFETIME_US: prdata = PDATA_W'(cfg_ff.lifetime_us);
         default:         prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

FILE: hw/rtl/stale_gated_window_average_unit.sv
// channel  | direction | handshake          | payload
// req      | in        | req_valid/stall    | action, temperature, time_now
// rsp      | out       | rsp_valid/stall    | average, average_valid, sample_accepted
// csr      | in/out    | psel/penable/pready| paddr, pwdata, prdata
//
// one item at a time; a sample item steps through accept, check and write, load result
// a query item does one history memory read per cycle, then the divider makes one
// quotient bit per cycle; a stale query clears history, an empty sweep skips division
// synchronous reset clears valid bits, write index, last sample time; presets registers
// a finished result waits in the output register while the next item is worked on
// a stalled result holds the output register and blocks only the next completion
module stale_gated_window_average_unit
   import sgwa_pkg::*;
#(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_action,
   input  logic signed [TEMP_W-1:0] req_temperature,
   input  logic [TIME_W-1:0]        req_time_now,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [TEMP_W-1:0] rsp_average,
   output logic                     rsp_average_valid,
   output logic                     rsp_sample_accepted,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [PADDR_W-1:0]       paddr,
   input  logic [PDATA_W-1:0]       pwdata,
   output logic [PDATA_W-1:0]       prdata,
   output logic                     pready
);

   localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
   localparam int SUM_W = TEMP_W + CNT_W;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(HISTORY_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(HISTORY_DEPTH - 1);

   cfg_type     cfg;
   div_rsp_type div_rsp;

   state_type   state_ff;
   state_type   state_in;

   // item
   logic                     act_ff;
   logic signed [TEMP_W-1:0] temp_ff;
   logic [TIME_W-1:0]        now_ff;

   // history state
   logic [HISTORY_DEPTH-1:0] valid_ff;
   logic [IDX_W-1:0]         wr_idx_ff;
   logic [TIME_W-1:0]        last_time_ff;

   // sweep
   logic [CNT_W-1:0]        scan_ff;
   logic [IDX_W-1:0]        rd_idx_ff;
   logic                    rd_pend_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic [CNT_W-1:0]        count_ff;
   logic [TEMP_W-1:0]       ram_rdata;

   // result slot and output register
   logic signed [TEMP_W-1:0] res_avg_ff;
   logic                     res_ok_ff;
   logic                     res_acc_ff;
   logic                     rsp_valid_ff;
   logic signed [TEMP_W-1:0] rsp_avg_ff;
   logic                     rsp_ok_ff;
   logic                     rsp_acc_ff;

   logic              in_range;
   logic [TIME_W-1:0] elapsed;
   logic              stale;
   logic              out_free;
   logic              ram_we;
   logic              ram_re;
   logic              div_start;
   logic              load_out;

   sgwa_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   sgwa_ram #(
      .WIDTH (TEMP_W),
      .DEPTH (HISTORY_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_idx_ff),
      .wr_data (temp_ff),
      .rd_en   (ram_re),
      .rd_addr (scan_ff[IDX_W-1:0]),
      .rd_data (ram_rdata)
   );

   sgwa_div #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .rsp      (div_rsp)
   );

   // range and staleness checks, output register free test
   always_comb begin
      in_range = ($signed(temp_ff) >= $signed(cfg.min_temp)) &&
                 ($signed(temp_ff) <= $signed(cfg.max_temp));
      elapsed  = now_ff - last_time_ff;
      stale    = (now_ff >= last_time_ff) && (elapsed > cfg.lifetime_us);
      out_free = !rsp_valid_ff || !rsp_stall;
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and control
   always_comb begin
      state_in  = state_ff;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      div_start = 1'b0;
      load_out  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (act_ff == ACTION_SAMPLE) begin
               ram_we   = in_range;
               state_in = ST_DONE;
            end else if (stale) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_ff != DEPTH_CNT) begin
               ram_re = 1'b1;
            end else begin
               state_in = ST_DIV_START;
            end
         end
         ST_DIV_START: begin
            if (count_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV_WAIT;
            end
         end
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   // history bookkeeping and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         wr_idx_ff    <= '0;
         last_time_ff <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ram_we) begin
            valid_ff[wr_idx_ff] <= 1'b1;
            last_time_ff        <= now_ff;
            wr_idx_ff           <= (wr_idx_ff == LAST_IDX) ? '0 : wr_idx_ff + IDX_W'(1);
         end
         if ((state_ff == ST_EXEC) && (act_ff == ACTION_QUERY) && stale) begin
            valid_ff  <= '0;
            wr_idx_ff <= '0;
         end
         rd_pend_ff <= ram_re;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // item capture, sweep accumulation and result payload
   always_ff @(posedge clock) begin
      if ((state_ff == ST_IDLE) && req_valid) begin
         act_ff  <= req_action;
         temp_ff <= req_temperature;
         now_ff  <= req_time_now;
      end
      if (state_ff == ST_EXEC) begin
         scan_ff    <= '0;
         sum_ff     <= '0;
         count_ff   <= '0;
         res_avg_ff <= '0;
         res_ok_ff  <= 1'b0;
         res_acc_ff <= (act_ff == ACTION_SAMPLE) && in_range;
      end
      if (state_ff == ST_SCAN) begin
         if (ram_re) begin
            scan_ff <= scan_ff + CNT_W'(1);
         end
         rd_idx_ff <= scan_ff[IDX_W-1:0];
         if (rd_pend_ff && valid_ff[rd_idx_ff]) begin
            sum_ff   <= sum_ff + {{(SUM_W - TEMP_W){ram_rdata[TEMP_W-1]}}, ram_rdata};
            count_ff <= count_ff + CNT_W'(1);
         end
      end
      if ((state_ff == ST_DIV_WAIT) && div_rsp.done) begin
         res_avg_ff <= div_rsp.quotient;
         res_ok_ff  <= 1'b1;
      end
      if (load_out) begin
         rsp_avg_ff <= res_avg_ff;
         rsp_ok_ff  <= res_ok_ff;
         rsp_acc_ff <= res_acc_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_average         = rsp_avg_ff;
   assign rsp_average_valid   = rsp_ok_ff;
   assign rsp_sample_accepted = rsp_acc_ff;

   // write index stays inside the ring
   a_wr_idx_range: assert property (@(posedge clock) disable iff (reset)
      wr_idx_ff <= LAST_IDX)
      else $error("write index outside history ring");

   // stale query drops the whole history
   a_stale_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && act_ff == ACTION_QUERY && stale)
      |=> (valid_ff == '0 && wr_idx_ff == '0))
      else $error("stale query did not clear history");

   // memory write and sweep read never share a cycle
   a_ram_excl: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("history write during sweep");

   // no mean without average_valid
   a_avg_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_average_valid) |-> (rsp_average == '0))
      else $error("nonzero average without valid flag");

   // an item is never both a stored sample and a reported mean
   a_result_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_average_valid && rsp_sample_accepted))
      else $error("result marked as both sample and mean");

endmodule

FILE: test/tb.sv
module tb;
   import sgwa_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int SETTLE_CYCLES = 60;
   localparam int LONG_HOLD_CYCLES = 400;

   typedef struct {
      logic                     action;
      logic signed [TEMP_W-1:0] temperature;
      logic [TIME_W-1:0]        time_now;
   } reading_type;

   typedef struct {
      logic signed [TEMP_W-1:0] average;
      logic                     average_valid;
      logic                     sample_accepted;
   } outcome_type;

   // clock, reset and block ports
   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_action = ACTION_SAMPLE;
   logic signed [TEMP_W-1:0] req_temperature = '0;
   logic [TIME_W-1:0]        req_time_now = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [TEMP_W-1:0] rsp_average;
   logic                     rsp_average_valid;
   logic                     rsp_sample_accepted;
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [PADDR_W-1:0]       paddr = '0;
   logic [PDATA_W-1:0]       pwdata = '0;
   logic [PDATA_W-1:0]       prdata;
   logic                     pready;

   // shadow of the registers and the history ring
   logic signed [TEMP_W-1:0] lo_limit = MIN_TEMP_RST;
   logic signed [TEMP_W-1:0] hi_limit = MAX_TEMP_RST;
   logic [TIME_W-1:0]        max_age = LIFETIME_US_RST;
   logic signed [TEMP_W-1:0] ring_value [HISTORY_DEPTH_DEF];
   logic [HISTORY_DEPTH_DEF-1:0] ring_valid = '0;
   int                       ring_ptr = 0;
   logic [TIME_W-1:0]        last_stamp = '0;

   // item flow bookkeeping
   reading_type queued_readings [$];
   outcome_type pending_results [$];
   reading_type next_reading;
   outcome_type want;
   int       total_queued = 0;
   int       accepted_count = 0;
   bit       req_taken = 1'b0;
   int       send_gap = 0;
   int       stall_left = 0;
   int       hold_left = 0;
   bit       long_hold_go = 1'b0;
   bit       calm = 1'b0;
   int       cycle_count = 0;
   int       mismatch_count = 0;

   stale_gated_window_average_unit DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_temperature(req_temperature),
      .req_time_now(req_time_now),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_average(rsp_average),
      .rsp_average_valid(rsp_average_valid),
      .rsp_sample_accepted(rsp_sample_accepted),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // expected outcome of one item, updates the shadow state
   function automatic outcome_type model_reading(input logic action,
                                                 input logic signed [TEMP_W-1:0] temp,
                                                 input logic [TIME_W-1:0] now);
      outcome_type r;
      int       sum;
      int       count;
      r.average = '0;
      r.average_valid = 1'b0;
      r.sample_accepted = 1'b0;
      sum = 0;
      count = 0;
      if (action == ACTION_SAMPLE) begin
         if (temp >= lo_limit && temp <= hi_limit) begin
            ring_value[ring_ptr] = temp;
            ring_valid[ring_ptr] = 1'b1;
            last_stamp = now;
            ring_ptr = (ring_ptr == HISTORY_DEPTH_DEF - 1) ? 0 : ring_ptr + 1;
            r.sample_accepted = 1'b1;
         end
      end else if (now >= last_stamp && (now - last_stamp) > max_age) begin
         // history too old: drop it all
         ring_valid = '0;
         ring_ptr = 0;
      end else begin
         for (int i = 0; i < HISTORY_DEPTH_DEF; i++) begin
            if (ring_valid[i]) begin
               sum += int'(ring_value[i]);
               count++;
            end
         end
         // int division truncates toward zero
         if (count > 0) begin
            r.average = TEMP_W'(sum / count);
            r.average_valid = 1'b1;
         end
      end
      return r;
   endfunction

   // item driver
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         req_taken = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (queued_readings.size() > 0) begin
            next_reading = queued_readings.pop_front();
            req_action <= next_reading.action;
            req_temperature <= next_reading.temperature;
            req_time_now <= next_reading.time_now;
            req_valid <= 1'b1;
            if (!calm && $urandom_range(0, 7) == 0)
               send_gap = $urandom_range(1, 18);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result stall: random bursts plus one long hold-off
   always @(negedge clock) begin
      if (long_hold_go) begin
         long_hold_go = 1'b0;
         hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (!calm && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 18);
      end
   end

   // monitor: check results, predict accepted items, watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("result arrived with no item outstanding");
               mismatch_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_average !== want.average) begin
                  $error("average: expected %0d, got %0d", want.average, rsp_average);
                  mismatch_count++;
               end
               if (rsp_average_valid !== want.average_valid) begin
                  $error("average_valid: expected %0d, got %0d",
                         want.average_valid, rsp_average_valid);
                  mismatch_count++;
               end
               if (rsp_sample_accepted !== want.sample_accepted) begin
                  $error("sample_accepted: expected %0d, got %0d",
                         want.sample_accepted, rsp_sample_accepted);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            pending_results.push_back(model_reading(req_action, req_temperature,
                                                    req_time_now));
            req_taken = 1'b1;
            accepted_count++;
         end
      end
   end

   task automatic add_reading(input logic action, input logic signed [TEMP_W-1:0] temp,
                              input logic [TIME_W-1:0] now);
      reading_type rd;
      rd.action = action;
      rd.temperature = temp;
      rd.time_now = now;
      queued_readings.push_back(rd);
      total_queued++;
   endtask

   // wait until every item is in and every result is out, then let the block settle
   task automatic drain();
      wait (accepted_count == total_queued);
      wait (pending_results.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one register write: setup cycle then access cycle
   task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 3'b000};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_MIN_TEMP: lo_limit = value[TEMP_W-1:0];
         REG_MAX_TEMP: hi_limit = value[TEMP_W-1:0];
         REG_LIFETIME_US: max_age = value[TIME_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic signed [TEMP_W-1:0] lo,
                                 input logic signed [TEMP_W-1:0] hi,
                                 input logic [TIME_W-1:0] age);
      write_reg(REG_MIN_TEMP, PDATA_W'(unsigned'(lo)));
      write_reg(REG_MAX_TEMP, PDATA_W'(unsigned'(hi)));
      write_reg(REG_LIFETIME_US, PDATA_W'(age));
   endtask

   // random register setting for one phase
   task automatic pick_settings();
      logic signed [TEMP_W-1:0] lo;
      logic signed [TEMP_W-1:0] hi;
      logic [TIME_W-1:0]        age;
      lo = MIN_TEMP_RST;
      hi = MAX_TEMP_RST;
      case ($urandom_range(0, 4))
         0: begin
            lo = -16'sd32768;
            hi = 16'sd32767;
         end
         1: begin
            lo = TEMP_W'(int'($urandom_range(0, 4000)) - 2000);
            hi = TEMP_W'(int'(lo) + int'($urandom_range(0, 8000)));
         end
         2: begin
            lo = TEMP_W'(int'($urandom_range(0, 400)) - 200);
            hi = lo;
         end
         3: ;
         default: begin
            lo = TEMP_W'($urandom);
            hi = TEMP_W'($urandom);
         end
      endcase
      case ($urandom_range(0, 4))
         0: age = '0;
         1: age = TIME_W'($urandom_range(1, 1000));
         2: age = LIFETIME_US_RST;
         3: age = '1;
         default: age = TIME_W'({$urandom, $urandom});
      endcase
      apply_settings(lo, hi, age);
   endtask

   // mostly well-formed sample/query sequences around the staleness edges, some noise
   task automatic queue_random_readings(input int n);
      logic [TIME_W-1:0]        gen_last;
      logic [TIME_W-1:0]        stamp;
      logic signed [TEMP_W-1:0] temp;
      int                       span;
      int                       pick;
      gen_last = last_stamp;
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            add_reading(1'($urandom_range(0, 1)), TEMP_W'($urandom),
                        TIME_W'({$urandom, $urandom}));
         end else if (pick < 65) begin
            // sample, usually in range
            stamp = gen_last + TIME_W'($urandom_range(0, 60000000));
            temp = TEMP_W'($urandom);
            if (lo_limit <= hi_limit && $urandom_range(0, 99) < 85) begin
               span = int'(hi_limit) - int'(lo_limit);
               case ($urandom_range(0, 9))
                  0: temp = lo_limit;
                  1: temp = hi_limit;
                  default: temp = TEMP_W'(int'(lo_limit) + int'($urandom_range(0, span)));
               endcase
            end
            if (temp >= lo_limit && temp <= hi_limit)
               gen_last = stamp;
            add_reading(ACTION_SAMPLE, temp, stamp);
         end else begin
            // query relative to the newest stored sample
            case ($urandom_range(0, 4))
               0, 1: stamp = gen_last + TIME_W'($urandom_range(0, 3));
               2: stamp = gen_last + max_age + TIME_W'($urandom_range(0, 2)) - TIME_W'(1);
               3: stamp = gen_last + TIME_W'({$urandom, $urandom});
               default: stamp = gen_last - TIME_W'($urandom_range(1, 1000));
            endcase
            add_reading(ACTION_QUERY, TEMP_W'($urandom), stamp);
         end
      end
   endtask

   // stimulus
   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: empty history, range bounds, lifetime edge, stale clear
      add_reading(ACTION_QUERY, TEMP_W'($urandom), 48'd0);
      add_reading(ACTION_SAMPLE, 16'sd512, 48'd100);
      add_reading(ACTION_SAMPLE, 16'sd10240, 48'd200);
      add_reading(ACTION_SAMPLE, 16'sd511, 48'd210);
      add_reading(ACTION_SAMPLE, 16'sd10241, 48'd220);
      add_reading(ACTION_QUERY, TEMP_W'($urandom), 48'd300);
      add_reading(ACTION_QUERY, TEMP_W'($urandom), 48'd900000200);
      add_reading(ACTION_QUERY, TEMP_W'($urandom), 48'd900000201);
      add_reading(ACTION_QUERY, TEMP_W'($urandom), 48'd900000202);
      // time going backwards never counts as stale
      add_reading(ACTION_SAMPLE, 16'sd1000, 48'd1000000000);
      add_reading(ACTION_QUERY, TEMP_W'($urandom), 48'd5);
      drain();

      // full range, zero lifetime: extreme values and negative truncation
      apply_settings(-16'sd32768, 16'sd32767, 48'd0);
      add_reading(ACTION_SAMPLE, -16'sd32768, 48'd10);
      add_reading(ACTION_SAMPLE, 16'sd32767, 48'd10);
      add_reading(ACTION_SAMPLE, -16'sd1, 48'd10);
      add_reading(ACTION_QUERY, TEMP_W'($urandom), 48'd10);
      add_reading(ACTION_SAMPLE, -16'sd3, 48'd10);
      add_reading(ACTION_QUERY, TEMP_W'($urandom), 48'd10);
      add_reading(ACTION_QUERY, TEMP_W'($urandom), 48'd11);
      add_reading(ACTION_SAMPLE, 16'sd32767, 48'hFFFF_FFFF_FFFF);
      add_reading(ACTION_QUERY, 16'sd0, 48'hFFFF_FFFF_FFFF);
      drain();

      // inverted range rejects everything, longest lifetime
      apply_settings(16'sd100, -16'sd100, 48'hFFFF_FFFF_FFFF);
      add_reading(ACTION_SAMPLE, 16'sd0, 48'd0);
      add_reading(ACTION_SAMPLE, 16'sd100, 48'd0);
      add_reading(ACTION_SAMPLE, -16'sd100, 48'd0);
      add_reading(ACTION_QUERY, TEMP_W'($urandom), 48'd0);
      drain();

      // random phases, one with a long result hold-off
      for (int p = 0; p < 5; p++) begin
         pick_settings();
         queue_random_readings(95);
         if (p == 2)
            long_hold_go = 1'b1;
         drain();
      end

      // closing phase at full rate
      calm = 1'b1;
      pick_settings();
      queue_random_readings(75);
      drain();

      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

FILE: stale_gated_window_average_unit.f
hw/rtl/sgwa_pkg.sv
hw/rtl/sgwa_ram.sv
hw/rtl/sgwa_div.sv
hw/rtl/sgwa_csr.sv
hw/rtl/stale_gated_window_average_unit.sv
test/tb.sv
